// ----- src/keyword_lexer_tokenizer_top_defines.svh -----
// Assertion macros shared by the keyword lexer RTL.
// Included by every module that carries concurrent checks; expects clk and rst_n in scope.
`ifndef KEYWORD_LEXER_TOKENIZER_TOP_DEFINES_SVH
`define KEYWORD_LEXER_TOKENIZER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication check.
`define KLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check.
`define KLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KLT_ASSERT_IMP(lbl, ante, cons, msg)
`define KLT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/klt_pkg.sv -----
// Shared types, token kind codes and character/keyword helper functions
// for the keyword lexer. No dependencies.
package klt_pkg;

  // Token kind codes.
  localparam logic [4:0] KIND_END    = 5'd0;
  localparam logic [4:0] KIND_SYM    = 5'd1;
  localparam logic [4:0] KIND_NUM    = 5'd2;
  localparam logic [4:0] KIND_WORD0  = 5'd3;
  localparam logic [4:0] KIND_PUNCT0 = 5'd13;
  localparam logic [4:0] KIND_GT     = 5'd19;
  localparam logic [4:0] KIND_LT     = 5'd20;
  localparam logic [4:0] KIND_GTE    = 5'd28;
  localparam logic [4:0] KIND_LTE    = 5'd29;
  localparam logic [4:0] KIND_ERR    = 5'd30;

  // Characters with a role of their own.
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_USC = 8'h5F;

  // Keyword table geometry.
  localparam int NUM_WORDS = 10;
  localparam logic [NUM_WORDS-1:0] WORDS_ALL = '1;
  localparam logic [3:0] SLEN_MAX = 4'd15;

  // Bundle queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // One token as it travels to the output.
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
  } tok_t;

  // All tokens caused by one input byte, at most three.
  typedef struct packed {
    logic [1:0]     cnt;
    tok_t [2:0]     tok;
  } bundle_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Running keyword match of a symbol.
  typedef struct packed {
    logic [NUM_WORDS-1:0] alive;
    logic [3:0]           len;
  } sym_acc_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64)) ||
           ((c >= 8'd91) && (c <= 8'd96)) || ((c >= 8'd123) && (c <= 8'd126));
  endfunction

  function automatic logic is_sym_part(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_USC);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
  endfunction

  // Kind of a listed punctuation byte, or the error kind if unlisted.
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h3A:   k = KIND_PUNCT0;          // colon
      8'h2E:   k = KIND_PUNCT0 + 5'd1;   // period
      8'h5B:   k = KIND_PUNCT0 + 5'd2;   // left bracket
      8'h5D:   k = KIND_PUNCT0 + 5'd3;   // right bracket
      8'h60:   k = KIND_PUNCT0 + 5'd4;   // backtick
      CH_USC:  k = KIND_PUNCT0 + 5'd5;
      CH_GT:   k = KIND_PUNCT0 + 5'd6;
      CH_LT:   k = KIND_PUNCT0 + 5'd7;
      8'h2B:   k = KIND_PUNCT0 + 5'd8;   // plus
      8'h2D:   k = KIND_PUNCT0 + 5'd9;   // minus
      8'h2A:   k = KIND_PUNCT0 + 5'd10;  // star
      8'h2F:   k = KIND_PUNCT0 + 5'd11;  // slash
      8'h27:   k = KIND_PUNCT0 + 5'd12;  // single quote
      8'h22:   k = KIND_PUNCT0 + 5'd13;  // double quote
      CH_EQ:   k = KIND_PUNCT0 + 5'd14;
      default: k = KIND_ERR;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] word_len(input logic [3:0] k);
    logic [3:0] l;
    case (k)
      4'd0:    l = 4'd6;
      4'd1:    l = 4'd4;
      4'd2:    l = 4'd6;
      4'd3:    l = 4'd6;
      4'd4:    l = 4'd5;
      4'd5:    l = 4'd4;
      4'd6:    l = 4'd5;
      4'd7:    l = 4'd7;
      4'd8:    l = 4'd7;
      4'd9:    l = 4'd2;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  // Keyword text, first letter in the top byte, padded with zero bytes.
  function automatic logic [55:0] word_txt(input logic [3:0] k);
    logic [55:0] t;
    case (k)
      4'd0:    t = {"marina", 8'h00};
      4'd1:    t = {"diso", 24'h0};
      4'd2:    t = {"forony", 8'h00};
      4'd3:    t = {"ataovy", 8'h00};
      4'd4:    t = {"baiko", 16'h0};
      4'd5:    t = {"raha", 24'h0};
      4'd6:    t = {"raiso", 16'h0};
      4'd7:    t = "kasoloy";
      4'd8:    t = "rambola";
      4'd9:    t = {"ho", 40'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  // Adds one character to a symbol and drops keywords that no longer match.
  function automatic sym_acc_t sym_take(input sym_acc_t acc, input logic [7:0] c);
    sym_acc_t   r;
    logic [7:0] lc;
    logic [55:0] txt;
    logic [5:0] sh;
    r  = acc;
    lc = to_lower(c);
    sh = 6'(7'd48 - {acc.len[2:0], 3'b000});
    for (int k = 0; k < NUM_WORDS; k++) begin
      txt = word_txt(4'(k));
      if ((acc.len >= word_len(4'(k))) || (8'(txt >> sh) != lc)) begin
        r.alive[k] = 1'b0;
      end
    end
    r.len = (acc.len == SLEN_MAX) ? SLEN_MAX : acc.len + 4'd1;
    return r;
  endfunction

  // Kind of a finished symbol: first keyword still alive with the exact length.
  function automatic logic [4:0] sym_kind(input sym_acc_t acc);
    logic [4:0] kd;
    kd = KIND_SYM;
    for (int k = NUM_WORDS - 1; k >= 0; k--) begin
      if (acc.alive[k] && (word_len(4'(k)) == acc.len)) begin
        kd = KIND_WORD0 + 5'(k);
      end
    end
    return kd;
  endfunction

endpackage

// ----- src/klt_channels.sv -----
// Handshake channel interfaces of the keyword lexer: source bytes in, tokens out.
// No dependencies.
interface klt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       final_req;

  modport source (output valid, ch, final_req, input ready);
  modport sink   (input valid, ch, final_req, output ready);
endinterface

interface klt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [15:0] tok_start;
  logic [15:0] tok_end;
  logic        run_last;

  modport source (output valid, kind, tok_start, tok_end, run_last, input ready);
  modport sink   (input valid, kind, tok_start, tok_end, run_last, output ready);
endinterface

// ----- src/klt_front.sv -----
// Front end of the keyword lexer: accepts source bytes, tracks lexer state and
// turns each byte into a bundle of up to three tokens. Uses klt_pkg and klt_in_if.
`include "keyword_lexer_tokenizer_top_defines.svh"

module klt_front import klt_pkg::*; #(
  parameter int POS_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  klt_in_if.sink     in_ch,
  input  q_stat_t    q_stat,
  output logic       push,
  output bundle_t    push_data
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_SYM  = 3'd1;
  localparam logic [2:0] M_NUM  = 3'd2;
  localparam logic [2:0] M_GT   = 3'd3;
  localparam logic [2:0] M_LT   = 3'd4;
  localparam logic [2:0] M_HALT = 3'd5;

  logic [2:0]           mode_r, mode_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] tbeg_r, tbeg_nxt;
  sym_acc_t             acc_r, acc_nxt;

  logic                 accept;
  logic [1:0]           n;
  tok_t [2:0]           toks;
  logic                 used;
  logic                 stop;
  logic [4:0]           pk;
  logic [POS_WIDTH-1:0] p1;

  function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] p);
    return (p == '1) ? p : p + 1'b1;
  endfunction

  // Positions leave the block as their low 16 bits.
  function automatic logic [15:0] pos16(input logic [POS_WIDTH-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[15:0];
  endfunction

  function automatic tok_t mk_tok(input logic [4:0] k, input logic [POS_WIDTH-1:0] s,
                                  input logic [POS_WIDTH-1:0] e);
    tok_t t;
    t.kind      = k;
    t.start_pos = pos16(s);
    t.end_pos   = pos16(e);
    return t;
  endfunction

  function automatic logic has_pend(input logic [2:0] md);
    return (md == M_SYM) || (md == M_NUM) || (md == M_GT) || (md == M_LT);
  endfunction

  // Token still held in the lexer state; a symbol or number is closed at position ep.
  function automatic tok_t pend_tok(input logic [2:0] md, input sym_acc_t acc,
                                    input logic [POS_WIDTH-1:0] tb,
                                    input logic [POS_WIDTH-1:0] ep);
    tok_t t;
    case (md)
      M_SYM:   t = mk_tok(sym_kind(acc), tb, ep);
      M_NUM:   t = mk_tok(KIND_NUM, tb, ep);
      M_GT:    t = mk_tok(KIND_GT, tb, sat_inc(tb));
      M_LT:    t = mk_tok(KIND_LT, tb, sat_inc(tb));
      default: t = '0;
    endcase
    return t;
  endfunction

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign p1          = sat_inc(pos_r);

  // Per-byte lexing: extend or close the pending token, handle the byte, final flag.
  always_comb begin
    n        = 2'd0;
    toks     = '0;
    used     = 1'b0;
    stop     = 1'b0;
    pk       = punct_kind(in_ch.ch);
    mode_nxt = mode_r;
    tbeg_nxt = tbeg_r;
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;

    if (mode_r == M_HALT) begin
      stop = 1'b1;
    end else begin
      if ((mode_r == M_SYM) && is_sym_part(in_ch.ch)) begin
        acc_nxt = sym_take(acc_r, in_ch.ch);
        used    = 1'b1;
      end else if ((mode_r == M_NUM) && is_digit(in_ch.ch)) begin
        used = 1'b1;
      end else if (((mode_r == M_GT) || (mode_r == M_LT)) && (in_ch.ch == CH_EQ)) begin
        toks[n]  = mk_tok((mode_r == M_GT) ? KIND_GTE : KIND_LTE, tbeg_r, p1);
        n        = n + 2'd1;
        mode_nxt = M_IDLE;
        used     = 1'b1;
      end else begin
        if (has_pend(mode_r)) begin
          toks[n] = pend_tok(mode_r, acc_r, tbeg_r, pos_r);
          n       = n + 2'd1;
        end
        mode_nxt = M_IDLE;
      end

      if (!used) begin
        if (is_space(in_ch.ch)) begin
          mode_nxt = M_IDLE;
        end else if (is_punct(in_ch.ch)) begin
          if (pk == KIND_ERR) begin
            toks[n]  = mk_tok(KIND_ERR, pos_r, p1);
            n        = n + 2'd1;
            mode_nxt = M_HALT;
            stop     = 1'b1;
          end else if (in_ch.ch == CH_GT) begin
            mode_nxt = M_GT;
            tbeg_nxt = pos_r;
          end else if (in_ch.ch == CH_LT) begin
            mode_nxt = M_LT;
            tbeg_nxt = pos_r;
          end else begin
            toks[n] = mk_tok(pk, pos_r, p1);
            n       = n + 2'd1;
          end
        end else if (is_digit(in_ch.ch)) begin
          mode_nxt = M_NUM;
          tbeg_nxt = pos_r;
        end else if (is_alpha(in_ch.ch)) begin
          mode_nxt = M_SYM;
          tbeg_nxt = pos_r;
          acc_nxt  = sym_take('{alive: WORDS_ALL, len: 4'd0}, in_ch.ch);
        end else begin
          toks[n]  = mk_tok(KIND_END, pos_r, pos_r);
          n        = n + 2'd1;
          mode_nxt = M_HALT;
          stop     = 1'b1;
        end
      end

      if (!stop) begin
        pos_nxt = p1;
        if (in_ch.final_req) begin
          if (has_pend(mode_nxt)) begin
            toks[n] = pend_tok(mode_nxt, acc_nxt, tbeg_nxt, p1);
            n       = n + 2'd1;
          end
          toks[n]  = mk_tok(KIND_END, p1, p1);
          n        = n + 2'd1;
          mode_nxt = M_HALT;
        end
      end
    end
  end

  assign push          = accept && (n != 2'd0);
  assign push_data.cnt = n;
  assign push_data.tok = toks;

  // Lexer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
      tbeg_r <= '0;
      acc_r  <= '{alive: WORDS_ALL, len: 4'd0};
    end else if (accept) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      tbeg_r <= tbeg_nxt;
      acc_r  <= acc_nxt;
    end
  end

  `KLT_ASSERT_NXT(a_halt_sticky, mode_r == M_HALT, mode_r == M_HALT, "lexer left halt")
  `KLT_ASSERT_NXT(a_halt_pos, mode_r == M_HALT, $stable(pos_r), "position moved in halt")

endmodule

// ----- src/klt_queue.sv -----
// Bundle queue between the lexer front end and the token serializer.
// Uses klt_pkg types; four entries held in registers.
`include "keyword_lexer_tokenizer_top_defines.svh"

module klt_queue import klt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output q_stat_t stat
);

  bundle_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rp_r];

  // Pointer and fill count updates.
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  `KLT_ASSERT_IMP(a_push_room, push, !stat.full, "push into full queue")
  `KLT_ASSERT_IMP(a_pop_data, pop, !stat.empty, "pop from empty queue")

endmodule

// ----- src/klt_back.sv -----
// Token serializer: takes bundles from the queue and sends their tokens one token
// at a time through a registered output stage. Uses klt_pkg and klt_out_if.
`include "keyword_lexer_tokenizer_top_defines.svh"

module klt_back import klt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  bundle_t   head,
  input  q_stat_t   q_stat,
  output logic      pop,
  klt_out_if.source out_ch
);

  logic       out_valid_r, out_valid_nxt;
  tok_t       out_tok_r;
  logic       out_last_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       last;

  // Load the next token whenever the queue holds one and the output stage is empty or being drained.
  assign load = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign last = (idx_r == (head.cnt - 2'd1));
  assign pop  = load && last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_tok_r  <= head.tok[idx_r];
      out_last_r <= last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_tok_r.kind;
  assign out_ch.tok_start = out_tok_r.start_pos;
  assign out_ch.tok_end   = out_tok_r.end_pos;
  assign out_ch.run_last  = out_last_r;

  `KLT_ASSERT_IMP(a_idx_range, !q_stat.empty, idx_r < head.cnt, "token index past bundle")
  `KLT_ASSERT_NXT(a_rest_follows, out_ch.valid && out_ch.ready && !out_ch.run_last,
                  out_ch.valid || !q_stat.empty, "bundle tail lost")

endmodule

// ----- src/keyword_lexer_tokenizer_top.sv -----
// Keyword lexer top level. A new source byte is accepted every cycle while the
// four-entry bundle queue has room; the front end lexes it in that same cycle and
// queues the zero to three tokens it causes. Tokens leave through a registered
// output stage at one per cycle while the receiver is ready, so the output port
// sets the sustained rate: one byte per cycle as long as bytes average at most
// one token each, with the queue absorbing bursts of punctuation and the final
// flush. Positions count in POS_WIDTH bits, saturate at the top, and are reported
// as their low 16 bits. There is no clearing pass after reset.
// Depends on klt_pkg, klt_channels, klt_front, klt_queue and klt_back.

module keyword_lexer_tokenizer_top import klt_pkg::*; #(
  parameter int POS_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  klt_in_if.sink    in_ch,
  klt_out_if.source out_ch
);

  logic    push;
  bundle_t push_data;
  logic    pop;
  bundle_t head;
  q_stat_t q_stat;

  // Byte classification and lexer state.
  klt_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // Decoupling queue.
  klt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // Token serializer.
  klt_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
